### design/pfs_pkg.sv
// Package for the programming frame serializer.
// Holds the family codes, sequencer state type, shifter control struct and
// the frame assembly functions. No dependencies.
package pfs_pkg;

    localparam int unsigned FrameMax   = 32;
    localparam int unsigned LenW       = 6;   // holds 0..FrameMax
    localparam int unsigned IdxW       = 5;   // bit position 0..FrameMax-1
    localparam int unsigned CmdW       = 8;
    localparam int unsigned PayW       = 24;
    localparam int unsigned FamW       = 2;

    typedef enum logic [1:0] {
        FAM_W4_P16   = 2'd0,
        FAM_W6_P14   = 2'd1,
        FAM_W8_P22   = 2'd2,
        FAM_W4_P24   = 2'd3
    } t_family;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SEND = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_shift_ctrl;

    // Frame word with the first bit to go out in bit 0.
    function automatic logic [FrameMax-1:0] build_frame(
        input t_family          fam,
        input logic [CmdW-1:0]  cmd,
        input logic [PayW-1:0]  pay
    );
        logic [FrameMax-1:0] msb_word;
        logic [FrameMax-1:0] word;
        msb_word = '0;
        word     = '0;
        case (fam)
            FAM_W4_P16: word = {12'd0, pay[15:0], cmd[3:0]};
            FAM_W6_P14: word = {10'd0, 1'b0, pay[13:0], 1'b0, cmd[5:0]};
            FAM_W8_P22: begin
                // MSB first: reverse so the command MSB leads
                msb_word = {cmd[7:0], 1'b0, pay[21:0], 1'b0};
                for (int i = 0; i < FrameMax; i++) begin
                    word[i] = msb_word[FrameMax-1-i];
                end
            end
            FAM_W4_P24: word = {4'd0, pay[23:0], cmd[3:0]};
            default:    word = '0;
        endcase
        return word;
    endfunction

    function automatic logic [LenW-1:0] frame_len(
        input t_family fam,
        input logic    has_pay
    );
        logic [LenW-1:0] len;
        case (fam)
            FAM_W4_P16: len = LenW'(20);
            FAM_W6_P14: len = has_pay ? LenW'(22) : LenW'(6);
            FAM_W8_P22: len = has_pay ? LenW'(32) : LenW'(8);
            FAM_W4_P24: len = LenW'(28);
            default:    len = LenW'(20);
        endcase
        return len;
    endfunction

endpackage

### design/programming_frame_serializer_core.sv
// Top level of the programming frame serializer: family register, frame
// shifter and half-bit sequencer. Depends on pfs_pkg, pfs_frame_shifter,
// pfs_sequencer.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  command  | i_valid / o_ready   | i_command, i_payload, i_has_payload
//  pins     | o_valid / i_ready   | o_clock_pin, o_data_pin, o_mode_pin, o_last
//  config   | i_cfg_we            | i_cfg_wdata (device family)
//
// A frame of N bits gives 2*N results, one per cycle while the pin side is
// ready, after the idle cycle that takes the command. The frame shift
// register moves one bit per two results. o_ready is high only between
// frames; the next command can be taken while the final result still waits
// in the output register.
// Reset (synchronous, active low) clears the sequencer and sets family 0.
module programming_frame_serializer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pfs_pkg::FamW-1:0]      i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pfs_pkg::CmdW-1:0]      i_command,
    input  logic [pfs_pkg::PayW-1:0]      i_payload,
    input  logic                          i_has_payload,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_clock_pin,
    output logic                          o_data_pin,
    output logic                          o_mode_pin,
    output logic                          o_last
);

    pfs_pkg::t_family      r_family;
    pfs_pkg::t_shift_ctrl  shift_ctrl;
    logic                  frame_bit;
    logic                  idle;
    logic                  in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family <= pfs_pkg::FAM_W4_P16;
        end else if (i_cfg_we) begin
            r_family <= pfs_pkg::t_family'(i_cfg_wdata);
        end
    end

    assign o_ready = idle;
    assign in_xfer = i_valid && idle;

    pfs_frame_shifter u_shifter (
        .i_clk     (i_clk),
        .i_ctrl    (shift_ctrl),
        .i_family  (r_family),
        .i_command (i_command),
        .i_payload (i_payload),
        .o_bit     (frame_bit)
    );

    pfs_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_xfer),
        .i_family      (r_family),
        .i_has_payload (i_has_payload),
        .i_bit         (frame_bit),
        .i_out_ready   (i_ready),
        .o_idle        (idle),
        .o_ctrl        (shift_ctrl),
        .o_valid       (o_valid),
        .o_clock_pin   (o_clock_pin),
        .o_data_pin    (o_data_pin),
        .o_mode_pin    (o_mode_pin),
        .o_last        (o_last)
    );

    // A taken command keeps the block busy for at least the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_ready)
        else $error("block ready straight after taking a command");

    // Mid-frame, a drained result is replaced at once.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_ready && o_valid && !o_last && i_ready) |=> o_valid)
        else $error("gap in half-bit stream mid-frame");

    // The final result of a frame is followed by a free output slot.
    a_last_then_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && i_ready) |=> (!o_valid || !o_last))
        else $error("back-to-back final half-bits");

endmodule

### design/pfs_frame_shifter.sv
// Frame shift register: loads the assembled frame and shifts out one bit
// per bit period. Depends on pfs_pkg.
module pfs_frame_shifter (
    input  logic                         i_clk,
    input  pfs_pkg::t_shift_ctrl         i_ctrl,
    input  pfs_pkg::t_family             i_family,
    input  logic [pfs_pkg::CmdW-1:0]     i_command,
    input  logic [pfs_pkg::PayW-1:0]     i_payload,
    output logic                         o_bit
);

    logic [pfs_pkg::FrameMax-1:0] r_frame;
    logic [pfs_pkg::FrameMax-1:0] n_frame;

    always_comb begin
        n_frame = r_frame;
        if (i_ctrl.load) begin
            n_frame = pfs_pkg::build_frame(i_family, i_command, i_payload);
        end else if (i_ctrl.shift) begin
            n_frame = {1'b0, r_frame[pfs_pkg::FrameMax-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    assign o_bit = r_frame[0];

endmodule

### design/pfs_sequencer.sv
// Half-bit sequencer: walks the frame two half-bits per bit and drives the
// output register. Depends on pfs_pkg.
module pfs_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  pfs_pkg::t_family      i_family,
    input  logic                  i_has_payload,
    input  logic                  i_bit,
    input  logic                  i_out_ready,
    output logic                  o_idle,
    output pfs_pkg::t_shift_ctrl  o_ctrl,
    output logic                  o_valid,
    output logic                  o_clock_pin,
    output logic                  o_data_pin,
    output logic                  o_mode_pin,
    output logic                  o_last
);

    pfs_pkg::t_state             r_state, n_state;
    logic                        r_half, n_half;
    logic [pfs_pkg::IdxW-1:0]    r_idx, n_idx;
    logic [pfs_pkg::LenW-1:0]    r_len, n_len;
    logic                        r_late, n_late;
    logic                        r_mode, n_mode;
    logic                        r_valid, n_valid;
    logic                        r_clock, n_clock;
    logic                        r_data, n_data;
    logic                        r_mode_out, n_mode_out;
    logic                        r_last, n_last;

    logic                        emit;
    logic                        final_bit;

    assign final_bit = ({1'b0, r_idx} == (r_len - pfs_pkg::LenW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfs_pkg::ST_IDLE;
            r_valid <= 1'b0;
            r_half  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_half  <= n_half;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_late     <= n_late;
        r_mode     <= n_mode;
        r_clock    <= n_clock;
        r_data     <= n_data;
        r_mode_out <= n_mode_out;
        r_last     <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_half     = r_half;
        n_idx      = r_idx;
        n_len      = r_len;
        n_late     = r_late;
        n_mode     = r_mode;
        n_clock    = r_clock;
        n_data     = r_data;
        n_mode_out = r_mode_out;
        n_last     = r_last;
        o_ctrl     = '0;
        emit       = 1'b0;
        n_valid    = (r_valid && !i_out_ready);

        case (r_state)
            pfs_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state     = pfs_pkg::ST_SEND;
                    n_half      = 1'b0;
                    n_idx       = '0;
                    n_len       = pfs_pkg::frame_len(i_family, i_has_payload);
                    n_late      = (i_family == pfs_pkg::FAM_W4_P24);
                    n_mode      = (i_family == pfs_pkg::FAM_W8_P22);
                    o_ctrl.load = 1'b1;
                end
            end
            pfs_pkg::ST_SEND: begin
                // output slot free or being drained this cycle
                emit = !r_valid || i_out_ready;
                if (emit) begin
                    n_valid    = 1'b1;
                    n_clock    = r_late ? r_half : !r_half;
                    n_data     = i_bit;
                    n_mode_out = r_mode;
                    n_last     = r_half && final_bit;
                    if (r_half) begin
                        n_half       = 1'b0;
                        n_idx        = r_idx + pfs_pkg::IdxW'(1);
                        o_ctrl.shift = 1'b1;
                        if (final_bit) begin
                            n_state = pfs_pkg::ST_IDLE;
                        end
                    end else begin
                        n_half = 1'b1;
                    end
                end
            end
            default: begin
                n_state = pfs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_idle      = (r_state == pfs_pkg::ST_IDLE);
    assign o_valid     = r_valid;
    assign o_clock_pin = r_clock;
    assign o_data_pin  = r_data;
    assign o_mode_pin  = r_mode_out;
    assign o_last      = r_last;

endmodule
